[hdl/sobel_3x3_edge_filter_unit_assert.svh]
// ----------------------------------------------------------------------------
// Sobel edge filter assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SOBEL_3X3_EDGE_FILTER_UNIT_ASSERT_SVH
`define SOBEL_3X3_EDGE_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTH

// lbl: property prop must hold at every clock edge outside reset
`define SOB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// lbl: condition cond must never be seen at a clock edge outside reset
`define SOB_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SOB_ASSERT(lbl, prop, msg)
`define SOB_NEVER(lbl, cond, msg)

`endif

`endif

[hdl/sob_pkg.sv]
// ----------------------------------------------------------------------------
// Sobel edge filter package
// Field widths, configuration register indexes and the front-to-back item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sob_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // One classified pixel: which results it causes and the 3x3 taps needed
    typedef struct packed {
        logic             has_int;
        logic             has_bord;
        logic [ROW_W-1:0] int_row;
        logic [COL_W-1:0] int_col;
        logic [ROW_W-1:0] pos_row;
        logic [COL_W-1:0] pos_col;
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] ml;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] tc;
        logic [PIX_W-1:0] bc;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] mr;
        logic [PIX_W-1:0] br;
    } op_t;

endpackage

[hdl/sob_front.sv]
// ----------------------------------------------------------------------------
// Sobel front end
// Raster counters, line stores and column window; classifies each pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sob_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int DEPTH      = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic [sob_pkg::PIX_W-1:0]         pixel,
    output logic                              full,
    input  logic                              cfg_restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   eff_height,
    input  logic [$clog2(DEPTH+1)-1:0]        q_count,
    output logic                              q_push,
    output sob_pkg::op_t                      q_op
);

    import sob_pkg::*;

    localparam int WCW  = $clog2(MAX_WIDTH + 1);
    localparam int HCW  = $clog2(MAX_HEIGHT + 1);
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

    logic [WCW-1:0] col_reg, col_next;
    logic [HCW-1:0] row_reg, row_next;
    logic [WCW-1:0] col_plus;
    logic [HCW-1:0] row_plus;
    logic           accept;
    logic           is_int, is_bord;

    logic             s1_valid_reg;
    logic             s1_int_reg, s1_bord_reg;
    logic [WCW-1:0]   s1_col_reg;
    logic [HCW-1:0]   s1_row_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [PIX_W-1:0] top_rd_reg, mid_rd_reg;
    logic [PIX_W-1:0] win_reg [6];

    assign full   = (q_count + CNTW'(s1_valid_reg)) >= CNTW'(DEPTH);
    assign accept = push && !full;

    assign col_plus = col_reg + 1'b1;
    assign row_plus = row_reg + 1'b1;

    // interior result for (r-1,c-1); border result for (r,c)
    assign is_int  = (row_reg >= HCW'(2)) && (col_reg >= WCW'(2));
    assign is_bord = (row_reg == '0) || (row_plus >= eff_height)
                  || (col_reg == '0) || (col_plus >= eff_width);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (col_plus >= eff_width)
            begin
                col_next = '0;
                row_next = (row_plus >= eff_height) ? '0 : row_plus;
            end
            else
            begin
                col_next = col_plus;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_rd_reg;
                win_reg[4] <= mid_rd_reg;
                win_reg[5] <= s1_px_reg;
            end
        end
    end

    // stage 1 payload and line store read, taken with the pixel
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= pixel;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_int_reg  <= is_int;
            s1_bord_reg <= is_bord;
            top_rd_reg  <= upper_mem[col_reg[AW-1:0]];
            mid_rd_reg  <= lower_mem[col_reg[AW-1:0]];
        end
    end

    // line stores roll down one row at the pixel's column
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            upper_mem[s1_col_reg[AW-1:0]] <= mid_rd_reg;
            lower_mem[s1_col_reg[AW-1:0]] <= s1_px_reg;
        end
    end

    assign q_push = s1_valid_reg && (s1_int_reg || s1_bord_reg);

    always_comb
    begin
        q_op.has_int  = s1_int_reg;
        q_op.has_bord = s1_bord_reg;
        q_op.int_row  = ROW_W'(s1_row_reg - 1'b1);
        q_op.int_col  = COL_W'(s1_col_reg - 1'b1);
        q_op.pos_row  = ROW_W'(s1_row_reg);
        q_op.pos_col  = COL_W'(s1_col_reg);
        q_op.tl       = win_reg[0];
        q_op.ml       = win_reg[1];
        q_op.bl       = win_reg[2];
        q_op.tc       = win_reg[3];
        q_op.bc       = win_reg[5];
        q_op.tr       = top_rd_reg;
        q_op.mr       = mid_rd_reg;
        q_op.br       = s1_px_reg;
    end

endmodule

[hdl/sob_opq.sv]
// ----------------------------------------------------------------------------
// Sobel item queue
// Short FIFO of classified pixels between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sobel_3x3_edge_filter_unit_assert.svh"

module sob_opq #(
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  sob_pkg::op_t                 push_op,
    input  logic                         pop,
    output logic                         head_valid,
    output sob_pkg::op_t                 head_op,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    import sob_pkg::*;

    localparam int PW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    op_t            slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_valid = (cnt_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];
    assign count      = cnt_reg;

    `SOB_NEVER(a_opq_overflow, push && !pop && (cnt_reg == CNTW'(DEPTH)), "item queue overflow")
    `SOB_NEVER(a_opq_underflow, pop && (cnt_reg == '0), "item queue popped while empty")
    `SOB_ASSERT(a_opq_ptr_gap, (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "pointers apart while empty")

endmodule

[hdl/sob_back.sv]
// ----------------------------------------------------------------------------
// Sobel back end
// Computes gradients and issues one or two results per item into the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sobel_3x3_edge_filter_unit_assert.svh"

module sob_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  sob_pkg::op_t                head_op,
    output logic                        q_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [sob_pkg::ROW_W-1:0]   out_row,
    output logic [sob_pkg::COL_W-1:0]   out_col,
    output logic [sob_pkg::PIX_W-1:0]   grad_x,
    output logic [sob_pkg::PIX_W-1:0]   grad_y,
    output logic [sob_pkg::PIX_W-1:0]   grad_sum,
    output logic                        last
);

    import sob_pkg::*;

    localparam int SW = PIX_W + 2;

    function automatic logic [PIX_W-1:0] clamp_diff(input logic [SW-1:0] pos,
                                                   input logic [SW-1:0] neg);
        logic [SW-1:0] d;
        begin
            d = pos - neg;
            if (pos <= neg)
            begin
                clamp_diff = '0;
            end
            else if (d > SW'(255))
            begin
                clamp_diff = '1;
            end
            else
            begin
                clamp_diff = d[PIX_W-1:0];
            end
        end
    endfunction

    logic             phase_reg, phase_next;
    logic             out_valid_reg, out_valid_next;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [PIX_W-1:0] gx_reg, gy_reg, sum_reg;
    logic             last_reg;

    logic             emit_int, load, op_done;
    logic [SW-1:0]    pos_x, neg_x, pos_y, neg_y;
    logic [PIX_W-1:0] gx_int, gy_int;
    logic [PIX_W:0]   sum_int;
    logic [ROW_W-1:0] res_row;
    logic [COL_W-1:0] res_col;
    logic [PIX_W-1:0] res_gx, res_gy, res_sum;
    logic             res_last;

    assign pos_x = SW'(head_op.tr) + {1'b0, head_op.mr, 1'b0} + SW'(head_op.br);
    assign neg_x = SW'(head_op.tl) + {1'b0, head_op.ml, 1'b0} + SW'(head_op.bl);
    assign pos_y = SW'(head_op.bl) + {1'b0, head_op.bc, 1'b0} + SW'(head_op.br);
    assign neg_y = SW'(head_op.tl) + {1'b0, head_op.tc, 1'b0} + SW'(head_op.tr);

    assign gx_int  = clamp_diff(pos_x, neg_x);
    assign gy_int  = clamp_diff(pos_y, neg_y);
    assign sum_int = {1'b0, gx_int} + {1'b0, gy_int};

    // interior result goes out first, border result of the same pixel second
    assign emit_int = head_op.has_int && !phase_reg;
    assign load     = head_valid && (!out_valid_reg || pop);
    assign op_done  = !emit_int || !head_op.has_bord;
    assign q_pop    = load && op_done;

    always_comb
    begin
        if (emit_int)
        begin
            res_row  = head_op.int_row;
            res_col  = head_op.int_col;
            res_gx   = gx_int;
            res_gy   = gy_int;
            res_sum  = sum_int[PIX_W] ? '1 : sum_int[PIX_W-1:0];
            res_last = !head_op.has_bord;
        end
        else
        begin
            res_row  = head_op.pos_row;
            res_col  = head_op.pos_col;
            res_gx   = head_op.br;
            res_gy   = '0;
            res_sum  = head_op.br;
            res_last = 1'b1;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            phase_next     = !op_done;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg  <= res_row;
            col_reg  <= res_col;
            gx_reg   <= res_gx;
            gy_reg   <= res_gy;
            sum_reg  <= res_sum;
            last_reg <= res_last;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_row  = row_reg;
    assign out_col  = col_reg;
    assign grad_x   = gx_reg;
    assign grad_y   = gy_reg;
    assign grad_sum = sum_reg;
    assign last     = last_reg;

    `SOB_ASSERT(a_back_phase_head, phase_reg |-> head_valid && head_op.has_int && head_op.has_bord, "second result pending without its item")
    `SOB_ASSERT(a_back_split, (load && emit_int && head_op.has_bord) |=> phase_reg, "interior result not followed by border result")
    `SOB_ASSERT(a_back_notlast, (out_valid_reg && !last_reg) |-> phase_reg, "non-final result shown with nothing to follow")

endmodule

[hdl/sobel_3x3_edge_filter_unit.sv]
// ----------------------------------------------------------------------------
// Sobel 3x3 edge filter unit
// Streaming horizontal and vertical Sobel gradients over a raster of
// grayscale pixels, tagged with row and column.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                Payload
//  --------  -----------------------  --------------------------------------
//  input     push / full              pixel
//  result    empty / pop              out_row out_col grad_x grad_y grad_sum last
//  config    cfg_valid / cfg_ready    cfg_index cfg_data
//
//  Cycles : one pixel item per clock while full is low; its first result passes the
//           line store read, the item queue and the output register.
//           Two-result pixels (last column, bottom row) slow input to one result a clock.
//  Reset  : row 0 / column 0, 640 x 480 clipped to the maximum; stores not cleared.
//  Stalls : full only when the item queue plus the line store stage would overflow;
//           a stalled result port holds its item while pixels fill the queue.
//
`timescale 1ns / 1ps

module sobel_3x3_edge_filter_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel input
    input  logic                            push,
    output logic                            full,
    input  logic [sob_pkg::PIX_W-1:0]       pixel,
    // results
    output logic                            empty,
    input  logic                            pop,
    output logic [sob_pkg::ROW_W-1:0]       out_row,
    output logic [sob_pkg::COL_W-1:0]       out_col,
    output logic [sob_pkg::PIX_W-1:0]       grad_x,
    output logic [sob_pkg::PIX_W-1:0]       grad_y,
    output logic [sob_pkg::PIX_W-1:0]       grad_sum,
    output logic                            last,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sob_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sob_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import sob_pkg::*;

    localparam int WCW       = $clog2(MAX_WIDTH + 1);
    localparam int HCW       = $clog2(MAX_HEIGHT + 1);
    localparam int OPQ_DEPTH = 4;
    localparam int CNTW      = $clog2(OPQ_DEPTH + 1);
    localparam int RST_W     = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int RST_H     = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    // Effective frame size: zero acts as one, oversize clips to the maximum
    logic [WCW-1:0] eff_width_reg, eff_width_next;
    logic [HCW-1:0] eff_height_reg, eff_height_next;
    logic [31:0]    wr_w, wr_h;
    logic           cfg_wr;

    logic            q_push, q_pop, head_valid;
    op_t             q_op, head_op;
    logic [CNTW-1:0] q_count;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign wr_w = 32'(cfg_data[CFG_WID_W-1:0]);
    assign wr_h = 32'(cfg_data[CFG_HGT_W-1:0]);

    always_comb
    begin
        eff_width_next  = eff_width_reg;
        eff_height_next = eff_height_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    if (wr_w == 32'd0)
                        eff_width_next = WCW'(1);
                    else if (wr_w > 32'(MAX_WIDTH))
                        eff_width_next = WCW'(MAX_WIDTH);
                    else
                        eff_width_next = WCW'(wr_w);
                end
                CFG_IMAGE_HEIGHT:
                begin
                    if (wr_h == 32'd0)
                        eff_height_next = HCW'(1);
                    else if (wr_h > 32'(MAX_HEIGHT))
                        eff_height_next = HCW'(MAX_HEIGHT);
                    else
                        eff_height_next = HCW'(wr_h);
                end
                default:
                begin
                    eff_width_next  = eff_width_reg;
                    eff_height_next = eff_height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_width_reg  <= WCW'(RST_W);
            eff_height_reg <= HCW'(RST_H);
        end
        else
        begin
            eff_width_reg  <= eff_width_next;
            eff_height_reg <= eff_height_next;
        end
    end

    // Front: counters, line stores, window, classification
    sob_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH      (OPQ_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pixel       (pixel),
        .full        (full),
        .cfg_restart (cfg_wr),
        .eff_width   (eff_width_reg),
        .eff_height  (eff_height_reg),
        .q_count     (q_count),
        .q_push      (q_push),
        .q_op        (q_op)
    );

    // Queue decoupling the two halves
    sob_opq #(
        .DEPTH (OPQ_DEPTH)
    ) u_opq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_op),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_op    (head_op),
        .count      (q_count)
    );

    // Back: gradient arithmetic and result sequencing
    sob_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .out_row    (out_row),
        .out_col    (out_col),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .grad_sum   (grad_sum),
        .last       (last)
    );

endmodule
